// File: rtl/wwe_pkg.sv
// ----------------------------------------------------------------------------
// wwe_pkg
// shared types, constants and the cordic angle table of the window weight
// evaluator
// ----------------------------------------------------------------------------
package wwe_pkg;

    localparam int ANGLE_STAGES_DEF     = 24;
    localparam int WEIGHT_FRAC_BITS_DEF = 30;

    localparam int CW = 34;   // cordic x / y width
    localparam int CZ = 33;   // cordic residual angle width
    localparam int WW = 36;   // internal weight width, q.30

    localparam logic       REG_WINDOW_TYPE = 1'b0;
    localparam logic       REG_INV_X_MAX   = 1'b1;

    localparam logic [2:0] WT_NONE     = 3'd0;
    localparam logic [2:0] WT_BARTLETT = 3'd1;
    localparam logic [2:0] WT_HANN     = 3'd2;
    localparam logic [2:0] WT_LANCZOS  = 3'd3;
    localparam logic [2:0] WT_NUTTALL  = 3'd4;
    localparam logic [2:0] WT_SINE     = 3'd5;
    localparam logic [2:0] WT_LORCH    = 3'd6;

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [WW-1:0] ONE_Q30     = WW'(64'sd1073741824);
    localparam logic signed [WW-1:0] MIN_Q       = -WW'(64'sd2147483648);
    localparam logic [31:0]          PI_Q30      = 32'd3373259426;
    localparam logic [29:0]          NUT_A0      = 30'd382002981;
    localparam logic [29:0]          NUT_A1      = 30'd523337470;
    localparam logic [29:0]          NUT_A2      = 30'd154867931;
    localparam logic [29:0]          NUT_A3      = 30'd13533442;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CZ-1:0] z;
    } t_cdat;

    typedef struct packed {
        logic [2:0]  wtype;
        logic        flag;
        logic [1:0]  quad;
        logic [32:0] t;
        logic [32:0] arg;
    } t_cside;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] acc;
        logic [31:0] den;
    } t_ddat;

    typedef struct packed {
        logic [2:0]           wtype;
        logic                 flag;
        logic                 neg;
        logic                 ovf;
        logic                 zero;
        logic signed [WW-1:0] wbase;
    } t_dside;

    function automatic logic signed [CZ-1:0] atan_turn(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            24: v = 30'd41;
            25: v = 30'd20;
            26: v = 30'd10;
            27: v = 30'd5;
            28: v = 30'd3;
            29: v = 30'd1;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return $signed({3'b000, v});
    endfunction

endpackage

// File: rtl/wwe_cordic_cell.sv
// ----------------------------------------------------------------------------
// wwe_cordic_cell
// one rotation-mode cordic iteration with a register, plus a passing sideband
// ----------------------------------------------------------------------------
module wwe_cordic_cell
    import wwe_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cdat             i_dat,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_cdat             o_dat,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    t_cdat             r_dat;
    logic [SIDE_W-1:0] r_side;
    t_cdat             n_dat;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb begin
        dx = i_dat.y >>> STAGE;
        dy = i_dat.x >>> STAGE;
        if (!i_dat.z[CZ-1]) begin
            n_dat.x = i_dat.x - dx;
            n_dat.y = i_dat.y + dy;
            n_dat.z = i_dat.z - atan_turn(STAGE);
        end else begin
            n_dat.x = i_dat.x + dx;
            n_dat.y = i_dat.y - dy;
            n_dat.z = i_dat.z + atan_turn(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dat  <= n_dat;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_dat   = r_dat;
    assign o_side  = r_side;

endmodule

// File: rtl/wwe_div_cell.sv
// ----------------------------------------------------------------------------
// wwe_div_cell
// one restoring division step with a register, plus a passing sideband
// ----------------------------------------------------------------------------
module wwe_div_cell
    import wwe_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_ddat             i_dat,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_ddat             o_dat,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    t_ddat             r_dat;
    logic [SIDE_W-1:0] r_side;
    t_ddat             n_dat;
    logic [32:0]       rem2;
    logic              ge;

    always_comb begin
        rem2      = {i_dat.rem, i_dat.acc[31]};
        ge        = rem2 >= {1'b0, i_dat.den};
        n_dat.rem = ge ? 32'(rem2 - {1'b0, i_dat.den}) : rem2[31:0];
        n_dat.acc = {i_dat.acc[30:0], ge};
        n_dat.den = i_dat.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dat  <= n_dat;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_dat   = r_dat;
    assign o_side  = r_side;

endmodule

// File: rtl/window_weight_evaluator.sv
// ----------------------------------------------------------------------------
// window_weight_evaluator
// window weight of one abscissa sample: none, bartlett, hann, lanczos,
// nuttall, one-minus-sine or lorch
// ----------------------------------------------------------------------------
// Takes one sample on every clock cycle; busy is never raised, and the
// receiver cannot stall the output. Each sample yields one result, strobed
// on o_done for a single cycle, in the order the samples came in. A sample
// passes the product and phase registers, the rows of cordic cells (one per
// angle stage in each), the post registers, the divider load register, the
// row of 32 divider cells for the sinc quotient and the output register.
module window_weight_evaluator
    import wwe_pkg::*;
#(
    parameter int ANGLE_STAGES     = ANGLE_STAGES_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_sample_x,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_weight,
    output logic               o_out_of_range
);

    localparam int N      = ANGLE_STAGES;
    localparam int DN     = 32;
    localparam int SHIFT  = 30 - WEIGHT_FRAC_BITS;
    localparam int CSW    = $bits(t_cside);
    localparam int DSW    = $bits(t_dside);

    function automatic logic [2*CW-1:0] quad_map(input t_cdat d, input logic [1:0] q);
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
        case (q)
            2'd0: begin
                c = d.x;  s = d.y;
            end
            2'd1: begin
                c = -d.y; s = d.x;
            end
            2'd2: begin
                c = -d.x; s = -d.y;
            end
            default: begin
                c = d.y;  s = -d.x;
            end
        endcase
        return {s, c};
    endfunction

    // configuration
    logic [2:0]  r_wtype;
    logic [31:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtype <= WT_NONE;
            r_inv   <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_TYPE: r_wtype <= i_cfg_data[2:0];
                REG_INV_X_MAX:   r_inv   <= i_cfg_data;
                default:         r_inv   <= r_inv;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: chi product
    logic        r_s1_valid;
    logic [2:0]  r_s1_wtype;
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start;
        end
        r_s1_wtype <= r_wtype;
        r_prod     <= i_sample_x * r_inv;
    end

    // stage 2: chi, t and phases
    logic        flag;
    logic [32:0] chi;
    logic [33:0] chi2;
    logic [34:0] chi3;
    logic [32:0] t;
    logic [31:0] ph0;
    logic [31:0] ph1;
    logic [31:0] ph2;

    always_comb begin
        flag = (r_prod[63:49] != '0) || (r_prod[48] && (r_prod[47:0] != '0));
        chi  = flag ? {1'b1, 32'd0} : r_prod[48:16];
        chi2 = {chi, 1'b0};
        chi3 = {1'b0, chi2} + {2'b00, chi};
        if (chi2 >= {2'b01, 32'd0}) begin
            t = 33'(chi2 - {2'b01, 32'd0});
        end else begin
            t = 33'({2'b01, 32'd0} - chi2);
        end
        case (r_s1_wtype)
            WT_SINE:    ph0 = {1'b0, chi[32:2]};
            WT_LANCZOS: ph0 = t[32:1];
            WT_LORCH:   ph0 = chi[32:1];
            default:    ph0 = chi[31:0];
        endcase
        ph1 = chi2[31:0];
        ph2 = chi3[31:0];
    end

    logic   r_s2_valid;
    t_cdat  r_s2_dat [0:2];
    t_cside r_s2_side;
    logic [1:0] r_s2_q1;
    logic [1:0] r_s2_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_dat[0]     <= '{x: CORDIC_GAIN, y: '0, z: $signed({3'b000, ph0[29:0]})};
        r_s2_dat[1]     <= '{x: CORDIC_GAIN, y: '0, z: $signed({3'b000, ph1[29:0]})};
        r_s2_dat[2]     <= '{x: CORDIC_GAIN, y: '0, z: $signed({3'b000, ph2[29:0]})};
        r_s2_side.wtype <= r_s1_wtype;
        r_s2_side.flag  <= flag;
        r_s2_side.quad  <= ph0[31:30];
        r_s2_side.t     <= t;
        r_s2_side.arg   <= (r_s1_wtype == WT_LANCZOS) ? t : chi;
        r_s2_q1         <= ph1[31:30];
        r_s2_q2         <= ph2[31:30];
    end

    // cordic rows
    logic            c_vld  [0:2][0:N];
    t_cdat           c_dat  [0:2][0:N];
    logic [CSW-1:0]  c_side0 [0:N];
    logic [1:0]      c_quad [1:2][0:N];

    assign c_vld[0][0]  = r_s2_valid;
    assign c_vld[1][0]  = r_s2_valid;
    assign c_vld[2][0]  = r_s2_valid;
    assign c_dat[0][0]  = r_s2_dat[0];
    assign c_dat[1][0]  = r_s2_dat[1];
    assign c_dat[2][0]  = r_s2_dat[2];
    assign c_side0[0]   = r_s2_side;
    assign c_quad[1][0] = r_s2_q1;
    assign c_quad[2][0] = r_s2_q2;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        wwe_cordic_cell #(.STAGE(i), .SIDE_W(CSW)) u_cell0 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_vld[0][i]),
            .i_dat   (c_dat[0][i]),
            .i_side  (c_side0[i]),
            .o_valid (c_vld[0][i+1]),
            .o_dat   (c_dat[0][i+1]),
            .o_side  (c_side0[i+1])
        );
        for (genvar l = 1; l < 3; l++) begin : g_lane
            wwe_cordic_cell #(.STAGE(i), .SIDE_W(2)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (c_vld[l][i]),
                .i_dat   (c_dat[l][i]),
                .i_side  (c_quad[l][i]),
                .o_valid (c_vld[l][i+1]),
                .o_dat   (c_dat[l][i+1]),
                .o_side  (c_quad[l][i+1])
            );
        end
    end

    // post 1: quadrant map and sinc divisor
    t_cside cs_end;
    logic [2*CW-1:0] sc0;
    logic [2*CW-1:0] sc1;
    logic [2*CW-1:0] sc2;

    assign cs_end = c_side0[N];
    assign sc0    = quad_map(c_dat[0][N], cs_end.quad);
    assign sc1    = quad_map(c_dat[1][N], c_quad[1][N]);
    assign sc2    = quad_map(c_dat[2][N], c_quad[2][N]);

    logic                 r_p1_valid;
    logic [2:0]           r_p1_wtype;
    logic                 r_p1_flag;
    logic [32:0]          r_p1_t;
    logic signed [CW-1:0] r_p1_s0;
    logic signed [CW-1:0] r_p1_c0;
    logic signed [CW-1:0] r_p1_c1;
    logic signed [CW-1:0] r_p1_c2;
    logic [64:0]          r_p1_dprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= c_vld[0][N] & c_vld[1][N] & c_vld[2][N];
        end
        r_p1_wtype <= cs_end.wtype;
        r_p1_flag  <= cs_end.flag;
        r_p1_t     <= cs_end.t;
        r_p1_s0    <= sc0[2*CW-1:CW];
        r_p1_c0    <= sc0[CW-1:0];
        r_p1_c1    <= sc1[CW-1:0];
        r_p1_c2    <= sc2[CW-1:0];
        r_p1_dprod <= cs_end.arg * PI_Q30;
    end

    // post 2: nuttall products, simple weights, sinc numerator
    logic signed [65:0]   m1;
    logic signed [65:0]   m2;
    logic signed [65:0]   m3;
    logic [31:0]          den;
    logic                 neg;
    logic [CW-1:0]        sa;
    logic signed [WW-1:0] wsimple;

    always_comb begin
        m1  = 66'(r_p1_c0) * $signed({1'b0, NUT_A1});
        m2  = 66'(r_p1_c1) * $signed({1'b0, NUT_A2});
        m3  = 66'(r_p1_c2) * $signed({1'b0, NUT_A3});
        den = r_p1_dprod[63:32];
        neg = r_p1_s0[CW-1];
        sa  = neg ? CW'(-r_p1_s0) : r_p1_s0;
        case (r_p1_wtype)
            WT_NONE:     wsimple = ONE_Q30;
            WT_BARTLETT: wsimple = $signed(WW'(({1'b1, 32'd0} - r_p1_t) >> 2));
            WT_HANN:     wsimple = (ONE_Q30 - WW'(r_p1_c0)) >>> 1;
            WT_SINE:     wsimple = ONE_Q30 - WW'(r_p1_s0);
            default:     wsimple = '0;
        endcase
    end

    logic                 r_p2_valid;
    logic [2:0]           r_p2_wtype;
    logic                 r_p2_flag;
    logic signed [WW-1:0] r_p2_n1;
    logic signed [WW-1:0] r_p2_n2;
    logic signed [WW-1:0] r_p2_n3;
    logic signed [WW-1:0] r_p2_wsimple;
    logic                 r_p2_neg;
    logic [CW-1:0]        r_p2_sa;
    logic [31:0]          r_p2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
        r_p2_wtype   <= r_p1_wtype;
        r_p2_flag    <= r_p1_flag;
        r_p2_n1      <= WW'(m1 >>> 30);
        r_p2_n2      <= WW'(m2 >>> 30);
        r_p2_n3      <= WW'(m3 >>> 30);
        r_p2_wsimple <= wsimple;
        r_p2_neg     <= neg;
        r_p2_sa      <= sa;
        r_p2_den     <= den;
    end

    // post 3: nuttall sum and divider load
    logic signed [WW-1:0] wnut;
    logic [31:0]          rem0;
    t_ddat                d_in;
    t_dside               ds_in;

    always_comb begin
        wnut        = $signed(WW'(NUT_A0)) - r_p2_n1 + r_p2_n2 - r_p2_n3;
        rem0        = 32'(r_p2_sa >> 2);
        d_in.rem    = rem0;
        d_in.acc    = {r_p2_sa[1:0], 30'd0};
        d_in.den    = r_p2_den;
        ds_in.wtype = r_p2_wtype;
        ds_in.flag  = r_p2_flag;
        ds_in.neg   = r_p2_neg;
        ds_in.ovf   = rem0 >= r_p2_den;
        ds_in.zero  = r_p2_den == '0;
        ds_in.wbase = (r_p2_wtype == WT_NUTTALL) ? wnut : r_p2_wsimple;
    end

    logic           r_d_valid;
    t_ddat          r_d_dat;
    t_dside         r_d_side;
    logic           d_vld  [0:DN];
    t_ddat          d_dat  [0:DN];
    logic [DSW-1:0] d_side [0:DN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_p2_valid;
        end
        r_d_dat  <= d_in;
        r_d_side <= ds_in;
    end

    assign d_vld[0]  = r_d_valid;
    assign d_dat[0]  = r_d_dat;
    assign d_side[0] = r_d_side;

    for (genvar k = 0; k < DN; k++) begin : g_div
        wwe_div_cell #(.SIDE_W(DSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_vld[k]),
            .i_dat   (d_dat[k]),
            .i_side  (d_side[k]),
            .o_valid (d_vld[k+1]),
            .o_dat   (d_dat[k+1]),
            .o_side  (d_side[k+1])
        );
    end

    // final selection, scaling and saturation
    t_dside               ds_end;
    logic [31:0]          q;
    logic signed [WW-1:0] wsinc;
    logic signed [WW-1:0] wsel;
    logic signed [WW-1:0] wsh;
    logic signed [31:0]   wout;

    always_comb begin
        ds_end = d_side[DN];
        q      = d_dat[DN].acc;
        if (ds_end.zero) begin
            wsinc = ONE_Q30;
        end else if (!ds_end.neg) begin
            wsinc = (ds_end.ovf || ({4'd0, q} > ONE_Q30)) ? ONE_Q30 : $signed({4'd0, q});
        end else begin
            wsinc = (ds_end.ovf || (q > 32'h8000_0000)) ? MIN_Q : -$signed({4'd0, q});
        end
        if ((ds_end.wtype == WT_LANCZOS) || (ds_end.wtype == WT_LORCH)) begin
            wsel = wsinc;
        end else begin
            wsel = ds_end.wbase;
        end
        wsh = wsel >>> SHIFT;
        if (wsh > $signed(WW'(32'h7FFF_FFFF))) begin
            wout = 32'sh7FFF_FFFF;
        end else if (wsh < MIN_Q) begin
            wout = 32'sh8000_0000;
        end else begin
            wout = wsh[31:0];
        end
    end

    logic               r_done;
    logic signed [31:0] r_weight;
    logic               r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld[DN];
        end
        r_weight <= wout;
        r_oor    <= ds_end.flag;
    end

    assign o_done         = r_done;
    assign o_weight       = r_weight;
    assign o_out_of_range = r_oor;

endmodule
